### rtl/gait_phase_detector_assert.svh
// assertion macros for the gait phase detector
`ifndef GAIT_PHASE_DETECTOR_ASSERT_SVH
`define GAIT_PHASE_DETECTOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define GPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gpd_pkg.sv
// shared types and constants for the gait phase detector
package gpd_pkg;

  localparam int unsigned DefaultPeriodUs = 1200000;
  localparam int unsigned ClockBits       = 40;

  localparam logic [2:0] RegSwingThr    = 3'd0;
  localparam logic [2:0] RegMotionThr   = 3'd1;
  localparam logic [2:0] RegSwingExit   = 3'd2;
  localparam logic [2:0] RegTimeout     = 3'd3;
  localparam logic [2:0] RegRestartThr  = 3'd4;
  localparam logic [2:0] RegStrideMin   = 3'd5;
  localparam logic [2:0] RegStrideMax   = 3'd6;
  localparam logic [2:0] RegWeight      = 3'd7;

  typedef enum logic [3:0] {
    StIdle, StEvent, StCheck, StDecide, StAvg, StRatio, StDivide,
    StPoly, StMul, StOut
  } state_e;

  typedef struct packed {
    logic load;        // take input beat
    logic event_step;  // clock and motion update
    logic check_step;  // timeout compare
    logic decide_step; // swing entry and exit handling
    logic avg_step;    // period average
    logic ratio_step;  // ratio setup
    logic div_step;    // one divider bit
    logic poly_step;   // polynomial base
    logic mul_step;    // one horner multiply
    logic out_step;    // finalize phase
  } cmd_t;

  typedef struct packed {
    logic timed_out;
    logic need_avg;
    logic div_done;
    logic started;
    logic ratio_full;
    logic mul_done;
  } stat_t;

endpackage

### rtl/gait_phase_detector.sv
// top level of the gait phase detector
//  channel  | dir | beat contents
//  s_axis   | in  | tdata[15:0] angular_speed, tdata[31:16] time_step_us
//  m_axis   | out | tdata[16:0] phase, tuser[0] swinging, tuser[1] idle
//  apb      | in  | eight registers at byte address 4*i
// a beat that times out skips the period update, 16-bit serial divide and three
// horner multiplies; a new beat is taken only after the last one is finished
// the output step is registered in pend_q, which loads the output register
// rst_ni clears the control state, registers return to their defaults
// the result is held in the output register until taken; the next beat may be
// accepted meanwhile and waits in its output step until the register is free
module gait_phase_detector #(
  parameter int unsigned DEFAULT_PERIOD_US = gpd_pkg::DefaultPeriodUs,
  parameter int unsigned CLOCK_BITS        = gpd_pkg::ClockBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // angular_speed, time_step_us
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // phase, zero fill
  output logic [1:0]  m_axis_tuser,   // swinging, idle
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "gait_phase_detector_assert.svh"

  gpd_pkg::cmd_t  cmd;
  gpd_pkg::stat_t stat;
  logic busy;
  logic in_fire;
  logic out_free;
  logic ovalid_q;
  logic [16:0] ophase_q;
  logic [1:0]  ouser_q;
  logic [16:0] phase;
  logic swinging, idle;

  logic [14:0] swing_thr_q, motion_thr_q, swing_exit_q;
  logic [23:0] timeout_q, stride_min_q, stride_max_q;
  logic [16:0] restart_thr_q;
  logic [8:0]  weight_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swing_thr_q   <= 15'd1000;
      motion_thr_q  <= 15'd500;
      swing_exit_q  <= 15'd700;
      timeout_q     <= 24'd2000000;
      restart_thr_q <= 17'd45875;
      stride_min_q  <= 24'd500000;
      stride_max_q  <= 24'd3000000;
      weight_q      <= 9'd77;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[4:2])
        gpd_pkg::RegSwingThr:   swing_thr_q   <= pwdata[14:0];
        gpd_pkg::RegMotionThr:  motion_thr_q  <= pwdata[14:0];
        gpd_pkg::RegSwingExit:  swing_exit_q  <= pwdata[14:0];
        gpd_pkg::RegTimeout:    timeout_q     <= pwdata[23:0];
        gpd_pkg::RegRestartThr: restart_thr_q <= pwdata[16:0];
        gpd_pkg::RegStrideMin:  stride_min_q  <= pwdata[23:0];
        gpd_pkg::RegStrideMax:  stride_max_q  <= pwdata[23:0];
        gpd_pkg::RegWeight:     weight_q      <= pwdata[8:0];
        default:                ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      gpd_pkg::RegSwingThr:   prdata = 32'(swing_thr_q);
      gpd_pkg::RegMotionThr:  prdata = 32'(motion_thr_q);
      gpd_pkg::RegSwingExit:  prdata = 32'(swing_exit_q);
      gpd_pkg::RegTimeout:    prdata = 32'(timeout_q);
      gpd_pkg::RegRestartThr: prdata = 32'(restart_thr_q);
      gpd_pkg::RegStrideMin:  prdata = 32'(stride_min_q);
      gpd_pkg::RegStrideMax:  prdata = 32'(stride_max_q);
      gpd_pkg::RegWeight:     prdata = 32'(weight_q);
      default:                prdata = '0;
    endcase
  end

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;

  gpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  gpd_datapath #(
    .DEFAULT_PERIOD_US (DEFAULT_PERIOD_US),
    .CLOCK_BITS        (CLOCK_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .speed_i       (s_axis_tdata[15:0]),
    .dt_i          (s_axis_tdata[31:16]),
    .swing_thr_i   (swing_thr_q),
    .motion_thr_i  (motion_thr_q),
    .swing_exit_i  (swing_exit_q),
    .timeout_i     (timeout_q),
    .restart_thr_i (restart_thr_q),
    .stride_min_i  (stride_min_q),
    .stride_max_i  (stride_max_q),
    .weight_i      (weight_q),
    .phase_o       (phase),
    .swinging_o    (swinging),
    .idle_o        (idle)
  );

  // output register, loaded from the finished state on the cycle after out_step
  logic pend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      pend_q <= cmd.out_step;
      if (pend_q) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      ophase_q <= phase;
      ouser_q  <= {idle, swinging};
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, ophase_q};
  assign m_axis_tuser  = ouser_q;

  `GPD_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, busy, !in_fire, "beat accepted while busy")
  `GPD_ASSERT_NEXT(a_load_out, clk_i, rst_ni, pend_q, m_axis_tvalid, "result not presented")
  `GPD_ASSERT_IMP(a_phase_range, clk_i, rst_ni, m_axis_tvalid, ophase_q <= 17'd65536,
                  "phase above one stride")

endmodule

### rtl/gpd_ctrl.sv
// sequencing state machine for the gait phase detector
module gpd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            out_free_i,
  input  gpd_pkg::stat_t  stat_i,
  output gpd_pkg::cmd_t   cmd_o,
  output logic            busy_o
);

  gpd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gpd_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gpd_pkg::StIdle:   if (in_fire_i) state_d = gpd_pkg::StEvent;
      gpd_pkg::StEvent:  state_d = gpd_pkg::StCheck;
      gpd_pkg::StCheck:  state_d = stat_i.timed_out ? gpd_pkg::StOut : gpd_pkg::StDecide;
      gpd_pkg::StDecide: state_d = stat_i.need_avg ? gpd_pkg::StAvg : gpd_pkg::StRatio;
      gpd_pkg::StAvg:    state_d = gpd_pkg::StRatio;
      gpd_pkg::StRatio: begin
        if (!stat_i.started) state_d = gpd_pkg::StOut;
        else if (stat_i.ratio_full) state_d = gpd_pkg::StPoly;
        else state_d = gpd_pkg::StDivide;
      end
      gpd_pkg::StDivide: if (stat_i.div_done) state_d = gpd_pkg::StPoly;
      gpd_pkg::StPoly:   state_d = gpd_pkg::StMul;
      gpd_pkg::StMul:    if (stat_i.mul_done) state_d = gpd_pkg::StOut;
      gpd_pkg::StOut:    if (out_free_i) state_d = gpd_pkg::StIdle;
      default:           state_d = gpd_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    case (state_q)
      gpd_pkg::StIdle: begin
        busy_o = 1'b0;
        cmd_o.load = in_fire_i;
      end
      gpd_pkg::StEvent:  cmd_o.event_step = 1'b1;
      gpd_pkg::StCheck:  cmd_o.check_step = 1'b1;
      gpd_pkg::StDecide: cmd_o.decide_step = 1'b1;
      gpd_pkg::StAvg:    cmd_o.avg_step = 1'b1;
      gpd_pkg::StRatio:  cmd_o.ratio_step = 1'b1;
      gpd_pkg::StDivide: cmd_o.div_step = !stat_i.div_done;
      gpd_pkg::StPoly:   cmd_o.poly_step = 1'b1;
      gpd_pkg::StMul:    cmd_o.mul_step = 1'b1;
      gpd_pkg::StOut:    cmd_o.out_step = out_free_i;
      default:           cmd_o = '0;
    endcase
  end

endmodule

### rtl/gpd_datapath.sv
// state registers, serial divider and horner multiplier of the detector
module gpd_datapath #(
  parameter int unsigned DEFAULT_PERIOD_US = gpd_pkg::DefaultPeriodUs,
  parameter int unsigned CLOCK_BITS        = gpd_pkg::ClockBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gpd_pkg::cmd_t   cmd_i,
  output gpd_pkg::stat_t  stat_o,
  input  logic [15:0]     speed_i,
  input  logic [15:0]     dt_i,
  input  logic [14:0]     swing_thr_i,
  input  logic [14:0]     motion_thr_i,
  input  logic [14:0]     swing_exit_i,
  input  logic [23:0]     timeout_i,
  input  logic [16:0]     restart_thr_i,
  input  logic [23:0]     stride_min_i,
  input  logic [23:0]     stride_max_i,
  input  logic [8:0]      weight_i,
  output logic [16:0]     phase_o,
  output logic            swinging_o,
  output logic            idle_o
);

  localparam int unsigned CB = CLOCK_BITS;

  logic [CB-1:0] clock_q, last_motion_q, stride_start_q;
  logic          started_q, swing_q;
  logic [23:0]   period_q;
  logic [16:0]   phase_q;
  logic          idle_q;
  logic [15:0]   mag_q;
  logic [15:0]   dt_q;
  logic [23:0]   meas_q;
  logic          timed_out_q;
  logic [16:0]   x_q;
  logic [CB:0]   rem_q;
  logic [4:0]    cnt_q;
  logic [1:0]    mcnt_q;
  logic [67:0]   v_q;

  logic [15:0]   mag_d;
  logic [CB-1:0] clk_next;
  logic [CB-1:0] elapsed;
  logic          timeout_hit;
  logic          need_avg;
  logic [CB:0]   rem_sh;
  logic [CB:0]   rem_sub;
  logic [8:0]    w_eff;
  logic [33:0]   x2;
  logic [67:0]   q_base;
  logic [84:0]   prod;
  logic [16:0]   fin;
  logic [51:0]   fin_full;

  assign mag_d    = speed_i[15] ? (16'd0 - speed_i) : speed_i;
  assign clk_next = clock_q + CB'(dt_q);
  assign elapsed  = clock_q - stride_start_q;
  assign timeout_hit = (clock_q - last_motion_q) > CB'(timeout_i);
  assign need_avg = !swing_q && (mag_q > 16'(swing_thr_i)) && started_q
                    && (phase_q > restart_thr_i)
                    && (elapsed > CB'(stride_min_i)) && (elapsed < CB'(stride_max_i));
  assign w_eff    = (weight_i > 9'd256) ? 9'd256 : weight_i;
  assign rem_sh   = {rem_q[CB-1:0], 1'b0};
  assign rem_sub  = rem_sh - (CB+1)'(period_q);
  assign x2       = 34'(x_q) * 34'(x_q);
  assign q_base   = 68'(6) * 68'(x2) + (68'd10 << 32) - 68'(15) * (68'(x_q) << 16);
  assign prod     = 85'(v_q) * 85'(x_q) + 85'd32768;
  assign fin_full = 52'(v_q) + 52'd32768;
  assign fin      = (fin_full[51:16] > 36'd65536) ? 17'd65536 : fin_full[32:16];

  assign stat_o.timed_out  = timeout_hit;
  assign stat_o.need_avg   = need_avg;
  assign stat_o.div_done   = (cnt_q == 5'd16);
  assign stat_o.started    = started_q;
  assign stat_o.ratio_full = (period_q == 24'd0) || (elapsed >= CB'(period_q));
  assign stat_o.mul_done   = (mcnt_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q        <= '0;
      last_motion_q  <= '0;
      stride_start_q <= '0;
      started_q      <= 1'b0;
      swing_q        <= 1'b0;
      period_q       <= 24'(DEFAULT_PERIOD_US);
      phase_q        <= '0;
      idle_q         <= 1'b0;
      timed_out_q    <= 1'b0;
      cnt_q          <= '0;
      mcnt_q         <= '0;
    end else begin
      if (cmd_i.event_step) begin
        clock_q <= clk_next;
        if ({1'b0, mag_q} > 17'(motion_thr_i)) last_motion_q <= clk_next;
      end
      if (cmd_i.check_step) begin
        timed_out_q <= timeout_hit;
        if (timeout_hit) phase_q <= '0;
        idle_q <= timeout_hit;
      end
      if (cmd_i.decide_step) begin
        if (!swing_q && mag_q > 16'(swing_thr_i)) begin
          swing_q <= 1'b1;
          if (started_q && phase_q > restart_thr_i) begin
            stride_start_q <= clock_q;
            phase_q <= '0;
          end else if (!started_q) begin
            started_q <= 1'b1;
            stride_start_q <= clock_q;
            phase_q <= '0;
          end
        end else if (swing_q && mag_q < 16'(swing_exit_i)) begin
          swing_q <= 1'b0;
        end
      end
      if (cmd_i.avg_step) begin
        period_q <= 24'((34'(period_q) * 34'(9'd256 - w_eff)
                       + 34'(meas_q) * 34'(w_eff) + 34'd128) >> 8);
      end
      if (cmd_i.ratio_step) cnt_q <= '0;
      if (cmd_i.div_step) cnt_q <= cnt_q + 5'd1;
      if (cmd_i.poly_step) mcnt_q <= '0;
      if (cmd_i.mul_step) mcnt_q <= mcnt_q + 2'd1;
      if (cmd_i.out_step && !timed_out_q && started_q) phase_q <= fin;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_d;
      dt_q  <= dt_i;
    end
    if (cmd_i.decide_step) meas_q <= elapsed[23:0];
    if (cmd_i.ratio_step) begin
      x_q   <= 17'd65536;
      rem_q <= {1'b0, elapsed};
    end
    if (cmd_i.div_step) begin
      if (!rem_sub[CB]) begin
        rem_q <= rem_sub;
        x_q   <= {((cnt_q == 5'd0) ? 16'd0 : x_q[15:0]), 1'b1};
      end else begin
        rem_q <= rem_sh;
        x_q   <= {((cnt_q == 5'd0) ? 16'd0 : x_q[15:0]), 1'b0};
      end
    end
    if (cmd_i.poly_step) v_q <= q_base;
    if (cmd_i.mul_step) v_q <= 68'(prod >> 16);
  end

  assign phase_o    = phase_q;
  assign swinging_o = swing_q;
  assign idle_o     = idle_q;

endmodule
